// ===== hdl/playfair_digraph_cipher_5x6_assert.svh =====
`ifndef PLAYFAIR_DIGRAPH_CIPHER_5X6_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_5X6_ASSERT_SVH

// same-cycle implication
`define PDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pdc_pkg.sv =====
package pdc_pkg;

    localparam int SYM_W        = 8;
    localparam int ROW_W        = 48;
    localparam int NUM_ROW_REGS = 5;
    localparam int MAX_COLS     = 8;
    localparam int ROW_EXT_W    = MAX_COLS * SYM_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int BURST_DEPTH  = 4;
    localparam int BURST_CNT_W  = $clog2(BURST_DEPTH + 1);

    localparam logic [SYM_W-1:0] SYM_PAD     = 8'h78;
    localparam logic [SYM_W-1:0] SYM_NEWLINE = 8'h0a;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 3'd0,
        CFG_ROW0 = 3'd1,
        CFG_ROW1 = 3'd2,
        CFG_ROW2 = 3'd3,
        CFG_ROW3 = 3'd4,
        CFG_ROW4 = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_IN_SQUARE = 2'd1,
        ST_ODD_LENGTH    = 2'd2
    } status_t;

    typedef logic [NUM_ROW_REGS-1:0][ROW_W-1:0] square_t;

    typedef struct packed {
        mode_t mode;
        logic  clear;
    } ctrl_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic             has_pair;
        logic             last;
        logic             odd;
    } job_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             data;
        logic             last;
        status_t          status;
    } result_t;

endpackage

// ===== hdl/pdc_cfg.sv =====
module pdc_cfg
    import pdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output ctrl_t                 ctrl,
    output square_t               square
);

    mode_t   mode_reg, mode_next;
    logic    mode_wr;
    square_t square_reg, square_next;

    always_comb begin
        mode_next   = mode_reg;
        mode_wr     = 1'b0;
        square_next = square_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE: begin
                    mode_next = mode_t'(cfg_wdata[0]);
                    mode_wr   = 1'b1;
                end
                CFG_ROW0: square_next[0] = cfg_wdata[ROW_W-1:0];
                CFG_ROW1: square_next[1] = cfg_wdata[ROW_W-1:0];
                CFG_ROW2: square_next[2] = cfg_wdata[ROW_W-1:0];
                CFG_ROW3: square_next[3] = cfg_wdata[ROW_W-1:0];
                CFG_ROW4: square_next[4] = cfg_wdata[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCRYPT;
            square_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            square_reg <= square_next;
        end
    end

    // message state clears at the same edge as the mode write
    assign ctrl   = '{mode: mode_reg, clear: mode_wr};
    assign square = square_reg;

endmodule

// ===== hdl/pdc_front.sv =====
module pdc_front
    import pdc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_t            ctrl,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [SYM_W-1:0] s_in_symbol,
    input  logic             s_in_last,
    output logic             q_push,
    output job_t             q_job,
    input  logic             q_full
);

    localparam logic [SYM_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [SYM_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LOWER_Z  = 8'h7a;
    localparam logic [SYM_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [SYM_W-1:0] CH_COMMA    = 8'h2c;
    localparam logic [SYM_W-1:0] CH_PERIOD   = 8'h2e;
    localparam logic [SYM_W-1:0] CH_QUESTION = 8'h3f;
    localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             hold_valid_reg, hold_valid_next;
    job_t             hold_job_reg, hold_job_next;

    logic             accept;
    logic             keep;
    logic [SYM_W-1:0] folded;
    job_t             job0, job1;
    logic [1:0]       njobs;

    function automatic job_t make_pair(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b);
        job_t j;
        j          = '0;
        j.sym_a    = a;
        j.sym_b    = b;
        j.has_pair = 1'b1;
        return j;
    endfunction

    assign s_ready = !hold_valid_reg && !q_full;
    assign accept  = s_valid && s_ready;

    // symbol set and case folding
    always_comb begin
        keep   = 1'b0;
        folded = s_in_symbol;
        if (s_in_symbol inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            keep   = 1'b1;
            folded = s_in_symbol + CASE_OFFSET;
        end else if (s_in_symbol inside {[CH_LOWER_A:CH_LOWER_Z], CH_SPACE, CH_COMMA,
                                          CH_PERIOD, CH_QUESTION}) begin
            keep = 1'b1;
        end
    end

    // pairing
    always_comb begin
        job0            = '0;
        job1            = '0;
        njobs           = 2'd0;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        if (ctrl.mode == MODE_ENCRYPT) begin
            if (keep) begin
                if (!pend_valid_reg) begin
                    pend_sym_next   = folded;
                    pend_valid_next = 1'b1;
                end else if (folded == pend_sym_reg) begin
                    job0  = make_pair(pend_sym_reg, SYM_PAD);
                    njobs = 2'd1;
                end else begin
                    job0            = make_pair(pend_sym_reg, folded);
                    njobs           = 2'd1;
                    pend_valid_next = 1'b0;
                end
            end
            if (s_in_last && pend_valid_next) begin
                if (njobs == 2'd0) begin
                    job0 = make_pair(pend_sym_next, SYM_PAD);
                end else begin
                    job1 = make_pair(pend_sym_next, SYM_PAD);
                end
                njobs = njobs + 2'd1;
            end
        end else begin
            if (s_in_symbol != SYM_NEWLINE) begin
                if (!pend_valid_reg) begin
                    pend_sym_next   = s_in_symbol;
                    pend_valid_next = 1'b1;
                end else begin
                    job0            = make_pair(pend_sym_reg, s_in_symbol);
                    njobs           = 2'd1;
                    pend_valid_next = 1'b0;
                end
            end
        end
        if (s_in_last) begin
            if (njobs == 2'd2) begin
                job1.last = 1'b1;
            end else begin
                job0.last = 1'b1;
                job0.odd  = (ctrl.mode == MODE_DECRYPT) && pend_valid_next;
                njobs     = 2'd1;
            end
            pend_valid_next = 1'b0;
        end
        if (!accept) begin
            pend_valid_next = pend_valid_reg;
            pend_sym_next   = pend_sym_reg;
        end
        if (ctrl.clear) begin
            pend_valid_next = 1'b0;
        end
    end

    // second request of a step is held until the queue has room
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_job_next   = hold_job_reg;
        if (hold_valid_reg && !q_full) begin
            hold_valid_next = 1'b0;
        end
        if (accept && njobs == 2'd2) begin
            hold_valid_next = 1'b1;
            hold_job_next   = job1;
        end
        if (ctrl.clear) begin
            hold_valid_next = 1'b0;
        end
    end

    assign q_push = hold_valid_reg ? !q_full : (accept && njobs != 2'd0);
    assign q_job  = hold_valid_reg ? hold_job_reg : job0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_sym_reg <= pend_sym_next;
        hold_job_reg <= hold_job_next;
    end

endmodule

// ===== hdl/pdc_queue.sv =====
module pdc_queue
    import pdc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/pdc_back.sv =====
module pdc_back
    import pdc_pkg::*;
#(
    parameter int SQUARE_ROWS = 5,
    parameter int SQUARE_COLS = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_t            ctrl,
    input  square_t          square,
    input  logic             q_empty,
    input  job_t             q_job,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_out_symbol,
    output logic             m_out_valid,
    output logic             m_out_last,
    output logic [1:0]       m_out_status
);

    localparam int RW    = $clog2(SQUARE_ROWS);
    localparam int CW    = $clog2(SQUARE_COLS);
    localparam int LOC_W = 1 + RW + CW;

    // lookup stage
    logic             a_valid_reg, a_valid_next;
    job_t             a_job_reg;
    logic [LOC_W-1:0] a_loc_a_reg, a_loc_b_reg;

    // result burst
    result_t              buf_reg [BURST_DEPTH];
    result_t              buf_next [BURST_DEPTH];
    logic [BURST_CNT_W-1:0] cnt_reg, cnt_next;

    // message state
    status_t          err_reg, err_next;
    logic             held_x_reg, held_x_next;
    logic [SYM_W-1:0] before_x_reg, before_x_next;
    logic             first_reg, first_next;

    logic             load;
    logic             found_a, found_b, pair_ok, inverse;
    logic [RW-1:0]    ra, rb;
    logic [CW-1:0]    ca, cb;
    logic [SYM_W-1:0] out_a, out_b, dec_sym;
    result_t          nb [BURST_DEPTH];
    logic [BURST_CNT_W-1:0] n_res;
    logic [1:0]       last_idx;

    function automatic logic [SYM_W-1:0] cell_at(input square_t sq, input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c);
        logic [ROW_EXT_W-1:0] ext;
        ext = ROW_EXT_W'(sq[r]);
        return ext[{c, 3'b000} +: SYM_W];
    endfunction

    function automatic logic [LOC_W-1:0] locate(input square_t sq, input logic [SYM_W-1:0] sym);
        logic          found;
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        found = 1'b0;
        r     = '0;
        c     = '0;
        for (int i = 0; i < SQUARE_ROWS; i++) begin
            for (int j = 0; j < SQUARE_COLS; j++) begin
                if (!found && cell_at(sq, RW'(i), CW'(j)) == sym) begin
                    found = 1'b1;
                    r     = RW'(i);
                    c     = CW'(j);
                end
            end
        end
        return {found, r, c};
    endfunction

    function automatic logic [CW-1:0] step_col(input logic [CW-1:0] c, input logic inv);
        if (inv) begin
            return (c == '0) ? CW'(SQUARE_COLS - 1) : c - CW'(1);
        end
        return (c == CW'(SQUARE_COLS - 1)) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [RW-1:0] step_row(input logic [RW-1:0] r, input logic inv);
        if (inv) begin
            return (r == '0) ? RW'(SQUARE_ROWS - 1) : r - RW'(1);
        end
        return (r == RW'(SQUARE_ROWS - 1)) ? '0 : r + RW'(1);
    endfunction

    function automatic result_t make_data(input logic [SYM_W-1:0] sym);
        result_t res;
        res        = '0;
        res.symbol = sym;
        res.data   = 1'b1;
        res.status = ST_OK;
        return res;
    endfunction

    assign load    = a_valid_reg && (cnt_reg == '0 || (cnt_reg == BURST_CNT_W'(1) && m_ready));
    assign q_pop   = !q_empty && (!a_valid_reg || load);
    assign m_valid = (cnt_reg != '0);

    assign m_out_symbol = buf_reg[0].symbol;
    assign m_out_valid  = buf_reg[0].data;
    assign m_out_last   = buf_reg[0].last;
    assign m_out_status = buf_reg[0].status;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (q_pop) begin
            a_valid_next = 1'b1;
        end else if (load) begin
            a_valid_next = 1'b0;
        end
    end

    assign {found_a, ra, ca} = a_loc_a_reg;
    assign {found_b, rb, cb} = a_loc_b_reg;
    assign pair_ok = found_a && found_b;
    assign inverse = (ctrl.mode == MODE_DECRYPT);

    // row, column and rectangle rules
    always_comb begin
        if (ra == rb) begin
            out_a = cell_at(square, ra, step_col(ca, inverse));
            out_b = cell_at(square, rb, step_col(cb, inverse));
        end else if (ca == cb) begin
            out_a = cell_at(square, step_row(ra, inverse), ca);
            out_b = cell_at(square, step_row(rb, inverse), cb);
        end else begin
            out_a = cell_at(square, ra, cb);
            out_b = cell_at(square, rb, ca);
        end
    end

    // results of one request, pad removal on the decrypt side
    always_comb begin
        err_next      = err_reg;
        held_x_next   = held_x_reg;
        before_x_next = before_x_reg;
        first_next    = first_reg;
        n_res         = '0;
        dec_sym       = '0;
        last_idx      = '0;
        for (int i = 0; i < BURST_DEPTH; i++) begin
            nb[i] = '0;
        end
        if (err_reg == ST_OK && a_job_reg.has_pair) begin
            if (!pair_ok) begin
                err_next = ST_NOT_IN_SQUARE;
            end else if (ctrl.mode == MODE_ENCRYPT) begin
                nb[0] = make_data(out_a);
                nb[1] = make_data(out_b);
                n_res = BURST_CNT_W'(2);
            end else begin
                for (int k = 0; k < 2; k++) begin
                    dec_sym = (k == 0) ? out_a : out_b;
                    if (!first_next) begin
                        first_next           = 1'b1;
                        before_x_next        = dec_sym;
                        nb[n_res[1:0]]       = make_data(dec_sym);
                        n_res                = n_res + BURST_CNT_W'(1);
                    end else begin
                        if (held_x_next) begin
                            if (before_x_next != dec_sym) begin
                                nb[n_res[1:0]] = make_data(SYM_PAD);
                                n_res          = n_res + BURST_CNT_W'(1);
                            end
                            held_x_next   = 1'b0;
                            before_x_next = SYM_PAD;
                        end
                        if (dec_sym == SYM_PAD) begin
                            held_x_next = 1'b1;
                        end else begin
                            before_x_next  = dec_sym;
                            nb[n_res[1:0]] = make_data(dec_sym);
                            n_res          = n_res + BURST_CNT_W'(1);
                        end
                    end
                end
            end
        end
        if (a_job_reg.last) begin
            if (a_job_reg.odd && err_next == ST_OK) begin
                err_next = ST_ODD_LENGTH;
            end
            if (n_res != '0 && err_next == ST_OK) begin
                last_idx          = n_res[1:0] - 2'd1;
                nb[last_idx].last = 1'b1;
            end else begin
                nb[n_res[1:0]] = '{symbol: '0, data: 1'b0, last: 1'b1, status: err_next};
                n_res          = n_res + BURST_CNT_W'(1);
            end
            err_next      = ST_OK;
            held_x_next   = 1'b0;
            before_x_next = '0;
            first_next    = 1'b0;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < BURST_DEPTH; i++) begin
            buf_next[i] = buf_reg[i];
        end
        if (m_valid && m_ready) begin
            for (int i = 0; i < BURST_DEPTH - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - BURST_CNT_W'(1);
        end
        if (load) begin
            for (int i = 0; i < BURST_DEPTH; i++) begin
                buf_next[i] = nb[i];
            end
            cnt_next = n_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            err_reg      <= ST_OK;
            held_x_reg   <= 1'b0;
            before_x_reg <= '0;
            first_reg    <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            cnt_reg     <= cnt_next;
            if (ctrl.clear) begin
                err_reg      <= ST_OK;
                held_x_reg   <= 1'b0;
                before_x_reg <= '0;
                first_reg    <= 1'b0;
            end else if (load) begin
                err_reg      <= err_next;
                held_x_reg   <= held_x_next;
                before_x_reg <= before_x_next;
                first_reg    <= first_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_job_reg   <= q_job;
            a_loc_a_reg <= locate(square, q_job.sym_a);
            a_loc_b_reg <= locate(square, q_job.sym_b);
        end
        for (int i = 0; i < BURST_DEPTH; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule

// ===== hdl/playfair_digraph_cipher_5x6.sv =====
// playfair digraph cipher over a loadable 5x6 key square
// config: software writes the five square rows and the mode through cfg_wr_en,
//   cfg_index and cfg_wdata while the block is idle; a mode write also clears
//   the open message
// input: one ascii byte per request on s_valid/s_ready, s_in_last marks the end
//   of the message
// output: zero to four result requests per input byte on m_valid/m_ready; a bare
//   end marker (m_out_valid low, m_out_last high) carries the error status
// with the back idle, the first result of a byte that closes a pair passes the
//   queue entry, the lookup register and the result register in that order
// throughput: one byte per cycle is taken while the queue has room, except while
//   the second request of a byte that closes two pairs is held; the back takes a
//   new pair once the last result of the one before leaves, and results leave at
//   one request per cycle while m_ready is high, about one per input byte on a
//   typical message; a four-entry request queue between the pairing front and
//   the lookup back lets the input keep flowing while results wait
// reset clears the mode to encrypt, the square to zero and all message state
// when the receiver stalls, the result register holds, the queue fills and then
//   s_ready drops
module playfair_digraph_cipher_5x6
    import pdc_pkg::*;
#(
    parameter int SQUARE_ROWS = 5,
    parameter int SQUARE_COLS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SYM_W-1:0]      s_in_symbol,
    input  logic                  s_in_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SYM_W-1:0]      m_out_symbol,
    output logic                  m_out_valid,
    output logic                  m_out_last,
    output logic [1:0]            m_out_status
);

    ctrl_t   ctrl;
    square_t square;
    logic    q_push, q_full, q_pop, q_empty;
    job_t    push_job, pop_job;

    pdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .square    (square)
    );

    pdc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_symbol (s_in_symbol),
        .s_in_last   (s_in_last),
        .q_push      (q_push),
        .q_job       (push_job),
        .q_full      (q_full)
    );

    pdc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    pdc_back #(
        .SQUARE_ROWS (SQUARE_ROWS),
        .SQUARE_COLS (SQUARE_COLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .square       (square),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_out_valid  (m_out_valid),
        .m_out_last   (m_out_last),
        .m_out_status (m_out_status)
    );

endmodule

// ===== hdl/pdc_checker.sv =====
`include "playfair_digraph_cipher_5x6_assert.svh"

module pdc_checker
    import pdc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SYM_W-1:0] m_out_symbol,
    input logic             m_out_valid,
    input logic             m_out_last,
    input logic [1:0]       m_out_status
);

    `PDC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_symbol) && $stable(m_out_valid) && $stable(m_out_last) && $stable(m_out_status), "result changed while stalled")

    `PDC_ASSERT_SAME(a_marker_form, aclk, aresetn, m_valid && !m_out_valid, m_out_last && m_out_symbol == '0, "end marker without last or with a symbol")

    `PDC_ASSERT_SAME(a_status_on_marker, aclk, aresetn, m_valid && m_out_status != ST_OK, !m_out_valid, "error status on a data result")

    `PDC_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_out_status == ST_OK || m_out_status == ST_NOT_IN_SQUARE || m_out_status == ST_ODD_LENGTH, "undefined status code")

endmodule

bind playfair_digraph_cipher_5x6 pdc_checker u_pdc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_symbol (m_out_symbol),
    .m_out_valid  (m_out_valid),
    .m_out_last   (m_out_last),
    .m_out_status (m_out_status)
);
